// ===== rtl/sft_pkg.sv =====
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants of the stuffed frame transmitter.
// ----------------------------------------------------------------------------
package sft_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_FLAG      = 3'd0;
   localparam logic [2:0] CSR_ESCAPE    = 3'd1;
   localparam logic [2:0] CSR_FLAG_CODE = 3'd2;
   localparam logic [2:0] CSR_ESC_ESC   = 3'd3;
   localparam logic [2:0] CSR_ADDRESS   = 3'd4;
   localparam logic [2:0] CSR_CTRL_SEQ0 = 3'd5;
   localparam logic [2:0] CSR_CTRL_SEQ1 = 3'd6;

   // Reset values of the symbol registers
   localparam logic [7:0] RST_FLAG      = 8'd126;
   localparam logic [7:0] RST_ESCAPE    = 8'd125;
   localparam logic [7:0] RST_FLAG_CODE = 8'd94;
   localparam logic [7:0] RST_ESC_ESC   = 8'd93;
   localparam logic [7:0] RST_ADDRESS   = 8'd3;
   localparam logic [7:0] RST_CTRL_SEQ0 = 8'd0;
   localparam logic [7:0] RST_CTRL_SEQ1 = 8'd64;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] flag;
      logic [7:0] escape;
      logic [7:0] flag_code;
      logic [7:0] esc_esc;
      logic [7:0] address;
      logic [7:0] ctrl_seq0;
      logic [7:0] ctrl_seq1;
   } cfg_type;

   // One classified payload byte
   typedef struct packed {
      logic [7:0] data;    // raw payload byte
      logic [7:0] check;   // running check including this byte
      logic       hdr;     // byte opens a frame
      logic       seq;     // sequence bit for the header
      logic       last;    // byte closes the frame
   } queue_entry_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_FLAG,
      PH_ADDR,
      PH_CTRL,
      PH_HCHK,
      PH_DATA,
      PH_DESC,
      PH_CHK,
      PH_CESC,
      PH_CLOSE
   } phase_type;

endpackage

// ===== rtl/sft_front.sv =====
// ----------------------------------------------------------------------------
// sft_front
// Accepts payload bytes, tracks frame state and running check, and hands
// classified entries to the queue.
// ----------------------------------------------------------------------------
module sft_front import sft_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [7:0] payload_byte
   input  logic            req_tuser,   // [0] sequence_bit
   input  logic            req_tlast,
   input  logic            q_full,
   output logic            q_push,
   output queue_entry_type q_entry
);

   logic       inside_ff, inside_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] new_check;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   // fold the byte into the check; a new frame starts from zero
   assign new_check = (inside_ff ? check_ff : 8'd0) ^ req_tdata;

   always_comb begin
      q_entry.data  = req_tdata;
      q_entry.check = new_check;
      q_entry.hdr   = !inside_ff;
      q_entry.seq   = req_tuser;
      q_entry.last  = req_tlast;
   end

   always_comb begin
      inside_in = inside_ff;
      check_in  = check_ff;
      if (q_push) begin
         inside_in = !req_tlast;
         check_in  = req_tlast ? 8'd0 : new_check;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         check_ff  <= 8'd0;
      end else begin
         inside_ff <= inside_in;
         check_ff  <= check_in;
      end
   end

endmodule

// ===== rtl/sft_queue.sv =====
// ----------------------------------------------------------------------------
// sft_queue
// Short FIFO of classified entries between front and back.
// ----------------------------------------------------------------------------
module sft_queue import sft_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            head_valid,
   output logic            full
);

   queue_entry_type        store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      cnt_ff, cnt_in;

   localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] LAST_PTR  = QPTR_W'(QUEUE_DEPTH - 1);

   assign head       = store_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == DEPTH_CNT);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/sft_back.sv =====
// ----------------------------------------------------------------------------
// sft_back
// Sequencer expanding the queue head into header, stuffed data, stuffed check
// and closing flag, one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module sft_back import sft_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  queue_entry_type head,
   input  logic            head_valid,
   output logic            head_pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] line_byte
   output logic            rsp_tuser,   // [0] end_of_frame
   output logic            rsp_tlast
);

   phase_type  phase_ff, phase_in;
   phase_type  cur_phase, nxt_phase;
   logic       advance;
   logic       done;
   logic       closing;
   logic [7:0] line_byte;
   logic [7:0] ctrl_byte;
   logic       data_flag, data_esc, chk_flag, chk_esc;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       user_ff, user_in;

   assign advance   = head_valid && (!valid_ff || rsp_tready);
   assign ctrl_byte = head.seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
   // flag test comes first, so flag wins when flag equals escape
   assign data_flag = (head.data == cfg.flag);
   assign data_esc  = (head.data == cfg.escape);
   assign chk_flag  = (head.check == cfg.flag);
   assign chk_esc   = (head.check == cfg.escape);

   // at the start of an entry pick header or data
   always_comb begin
      if (phase_ff == PH_START) begin
         cur_phase = head.hdr ? PH_FLAG : PH_DATA;
      end else begin
         cur_phase = phase_ff;
      end
   end

   // next state
   always_comb begin
      unique case (cur_phase)
         PH_FLAG:  nxt_phase = PH_ADDR;
         PH_ADDR:  nxt_phase = PH_CTRL;
         PH_CTRL:  nxt_phase = PH_HCHK;
         PH_HCHK:  nxt_phase = PH_DATA;
         PH_DATA: begin
            if (data_flag || data_esc) nxt_phase = PH_DESC;
            else if (head.last)        nxt_phase = PH_CHK;
            else                       nxt_phase = PH_START;
         end
         PH_DESC:  nxt_phase = head.last ? PH_CHK : PH_START;
         PH_CHK:   nxt_phase = (chk_flag || chk_esc) ? PH_CESC : PH_CLOSE;
         PH_CESC:  nxt_phase = PH_CLOSE;
         PH_CLOSE: nxt_phase = PH_START;
         default:  nxt_phase = PH_START;
      endcase
      phase_in = advance ? nxt_phase : phase_ff;
   end

   // outputs of the current phase
   always_comb begin
      closing = 1'b0;
      unique case (cur_phase)
         PH_FLAG:  line_byte = cfg.flag;
         PH_ADDR:  line_byte = cfg.address;
         PH_CTRL:  line_byte = ctrl_byte;
         PH_HCHK:  line_byte = cfg.address ^ ctrl_byte;
         PH_DATA:  line_byte = (data_flag || data_esc) ? cfg.escape : head.data;
         PH_DESC:  line_byte = data_flag ? cfg.flag_code : cfg.esc_esc;
         PH_CHK:   line_byte = (chk_flag || chk_esc) ? cfg.escape : head.check;
         PH_CESC:  line_byte = chk_flag ? cfg.flag_code : cfg.esc_esc;
         PH_CLOSE: begin
            line_byte = cfg.flag;
            closing   = 1'b1;
         end
         default:  line_byte = cfg.flag;
      endcase
      done     = (nxt_phase == PH_START);
      head_pop = advance && done;
   end

   // output register
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = line_byte;
         last_in  = done;
         user_in  = closing;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ===== rtl/stuffed_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_transmitter
// Byte-stuffing frame builder with header, XOR check and closing flag.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  req_     in         payload byte, tuser = sequence bit, tlast = last of frame
//  rsp_     out        line byte, tlast = end of run, tuser = end of frame
//  csr_     in         symbol register write, index 0..6, others ignored
//
//  Each payload byte yields 1 to 9 line bytes, one per cycle; the back-end
//  sequencer emitting one byte a cycle while rsp_ is not stalled sets the rate.
//  A two-entry queue lets the front accept a byte per cycle while it has room.
//  Synchronous active-high reset empties the queue and closes any open frame.
//  A stalled rsp_ holds its byte and the back waits for the output register.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter import sft_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] payload_byte
   input  logic       req_tuser,   // [0] sequence_bit
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tuser,   // [0] end_of_frame
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   logic            q_full, q_push, q_pop, q_valid;
   queue_entry_type q_entry, q_head;

   // symbol registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FLAG:      cfg_in.flag      = csr_wdata;
            CSR_ESCAPE:    cfg_in.escape    = csr_wdata;
            CSR_FLAG_CODE: cfg_in.flag_code = csr_wdata;
            CSR_ESC_ESC:   cfg_in.esc_esc   = csr_wdata;
            CSR_ADDRESS:   cfg_in.address   = csr_wdata;
            CSR_CTRL_SEQ0: cfg_in.ctrl_seq0 = csr_wdata;
            CSR_CTRL_SEQ1: cfg_in.ctrl_seq1 = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag      <= RST_FLAG;
         cfg_ff.escape    <= RST_ESCAPE;
         cfg_ff.flag_code <= RST_FLAG_CODE;
         cfg_ff.esc_esc   <= RST_ESC_ESC;
         cfg_ff.address   <= RST_ADDRESS;
         cfg_ff.ctrl_seq0 <= RST_CTRL_SEQ0;
         cfg_ff.ctrl_seq1 <= RST_CTRL_SEQ1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   sft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_valid),
      .full       (q_full)
   );

   sft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (q_head),
      .head_valid (q_valid),
      .head_pop   (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/sft_checker.sv =====
// ----------------------------------------------------------------------------
// sft_checker
// Port-level checks of the stuffed frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module sft_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled output transaction holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // the closing flag always ends its run
   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("closing flag not marked end of run");

   // reset leaves no output pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   // reset leaves the queue empty, so input is taken at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

endmodule

bind stuffed_frame_transmitter sft_checker u_sft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/stuffed_frame_transmitter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stuffed_frame_transmitter_test
// Self-checking bench for the byte-stuffing frame transmitter.
//
// Payload bytes are pushed through req_, and every line byte on rsp_ is
// checked against a frame builder kept inside the bench: header on a frame's
// first byte, stuffed payload, stuffed XOR check and closing flag. A short
// directed set covers the corner cases. Random frames follow under several
// symbol settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter_test;
   import sft_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd7;   // index with no register behind it
   localparam int DRAIN_CYCLES       = 12;
   localparam int STALL_LIMIT        = 2000;
   localparam int RANDOM_PER_SETTING = 19;

   // -------------------------------------------------------------------------
   // Frame builder and line byte checker
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      typedef struct {
         logic [7:0] line_byte;
         logic       end_of_run;
         logic       end_of_frame;
      } line_item_type;

      cfg_type       symbols;
      bit            frame_open;
      logic [7:0]    frame_check;
      line_item_type line_bytes_due[$];
      int            payload_count;
      int            frame_count;
      int            line_count;
      int            escape_count;
      int            mismatch_count;

      function new();
         symbols = '{flag: RST_FLAG, escape: RST_ESCAPE, flag_code: RST_FLAG_CODE,
                     esc_esc: RST_ESC_ESC, address: RST_ADDRESS,
                     ctrl_seq0: RST_CTRL_SEQ0, ctrl_seq1: RST_CTRL_SEQ1};
         frame_open  = 1'b0;
         frame_check = 8'h00;
      endfunction

      function int pending();
         return line_bytes_due.size();
      endfunction

      function void set_register(logic [2:0] index, logic [7:0] value);
         case (index)
            CSR_FLAG:      symbols.flag      = value;
            CSR_ESCAPE:    symbols.escape    = value;
            CSR_FLAG_CODE: symbols.flag_code = value;
            CSR_ESC_ESC:   symbols.esc_esc   = value;
            CSR_ADDRESS:   symbols.address   = value;
            CSR_CTRL_SEQ0: symbols.ctrl_seq0 = value;
            CSR_CTRL_SEQ1: symbols.ctrl_seq1 = value;
            default: ;
         endcase
      endfunction

      function void emit(logic [7:0] value, logic closing);
         line_item_type item;
         item.line_byte    = value;
         item.end_of_run   = 1'b0;
         item.end_of_frame = closing;
         line_bytes_due.push_back(item);
      endfunction

      // flag test first, so a flag equal to escape goes out as escape + flag code
      function void emit_stuffed(logic [7:0] value);
         if (value == symbols.flag) begin
            emit(symbols.escape, 1'b0);
            emit(symbols.flag_code, 1'b0);
            escape_count++;
         end else if (value == symbols.escape) begin
            emit(symbols.escape, 1'b0);
            emit(symbols.esc_esc, 1'b0);
            escape_count++;
         end else begin
            emit(value, 1'b0);
         end
      endfunction

      // expected line bytes for one accepted payload transaction
      function void note_payload(logic [7:0] data, logic seq, logic last);
         logic [7:0] ctrl;
         int         tail;
         payload_count++;
         if (!frame_open) begin
            ctrl = seq ? symbols.ctrl_seq1 : symbols.ctrl_seq0;
            emit(symbols.flag, 1'b0);
            emit(symbols.address, 1'b0);
            emit(ctrl, 1'b0);
            emit(symbols.address ^ ctrl, 1'b0);
            frame_open  = 1'b1;
            frame_check = 8'h00;
         end
         frame_check = frame_check ^ data;
         emit_stuffed(data);
         if (last) begin
            emit_stuffed(frame_check);
            emit(symbols.flag, 1'b1);
            frame_open  = 1'b0;
            frame_check = 8'h00;
            frame_count++;
         end
         tail = line_bytes_due.size() - 1;
         line_bytes_due[tail].end_of_run = 1'b1;
      endfunction

      function void report_mismatch(string detail);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] line byte %0d: %s", $time, line_count, detail);
      endfunction

      function void check_line_byte(logic [7:0] value, logic eor, logic eof);
         line_item_type want;
         line_count++;
         if (line_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected, got %02h eor %0b eof %0b",
                                      value, eor, eof));
            return;
         end
         want = line_bytes_due.pop_front();
         if (value !== want.line_byte || eor !== want.end_of_run
             || eof !== want.end_of_frame)
            report_mismatch($sformatf("expected %02h eor %0b eof %0b, got %02h eor %0b eof %0b",
                                      want.line_byte, want.end_of_run, want.end_of_frame,
                                      value, eor, eof));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic [2:0] csr_index  = 3'd0;
   logic [7:0] csr_wdata  = 8'h00;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int stall_cycles   = 0;
   int settings_count = 0;

   frame_scoreboard sb = new();

   always #2 clock = ~clock;

   stuffed_frame_transmitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] payload_byte
      .req_tuser  (req_tuser),    // [0] sequence_bit
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] line_byte
      .rsp_tuser  (rsp_tuser),    // [0] end_of_frame
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // line bytes: signals settle by the falling edge, accepted at the next rising one
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_line_byte(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // watchdog on cycles without any transaction
   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d line bytes pending",
                  stall_cycles, sb.pending());
         $display("simulation failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_payload(input logic [7:0] data, input logic seq, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= seq;
      req_tlast  <= last;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sb.note_payload(data, seq, last);
   endtask

   // stop sending and let every expected line byte come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   // full symbol set, plus a write to the unused index that must change nothing
   task automatic apply_settings(input cfg_type c);
      drain();
      write_register(CSR_FLAG, c.flag);
      write_register(CSR_ESCAPE, c.escape);
      write_register(CSR_FLAG_CODE, c.flag_code);
      write_register(CSR_ESC_ESC, c.esc_esc);
      write_register(CSR_ADDRESS, c.address);
      write_register(CSR_CTRL_SEQ0, c.ctrl_seq0);
      write_register(CSR_CTRL_SEQ1, c.ctrl_seq1);
      write_register(CSR_UNUSED, 8'($urandom_range(255)));
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic cfg_type random_symbols();
      cfg_type c;
      c.flag      = 8'($urandom_range(255));
      c.escape    = ($urandom_range(7) == 0) ? c.flag : 8'($urandom_range(255));
      c.flag_code = 8'($urandom_range(255));
      c.esc_esc   = 8'($urandom_range(255));
      c.address   = 8'($urandom_range(255));
      c.ctrl_seq0 = 8'($urandom_range(255));
      c.ctrl_seq1 = 8'($urandom_range(255));
      return c;
   endfunction

   // lean on the symbol values so stuffing happens often
   function automatic logic [7:0] random_payload();
      case ($urandom_range(5))
         0:       return sb.symbols.flag;
         1:       return sb.symbols.escape;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      cfg_type shared_symbols;
      cfg_type extreme_symbols;
      shared_symbols  = '{flag: 8'h55, escape: 8'h55, flag_code: 8'h7E, esc_esc: 8'hAA,
                          address: 8'h55, ctrl_seq0: 8'h7D, ctrl_seq1: 8'h55};
      extreme_symbols = '{flag: 8'h00, escape: 8'hFF, flag_code: 8'hFF, esc_esc: 8'h00,
                          address: 8'hFF, ctrl_seq0: 8'h00, ctrl_seq1: 8'hFF};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      rsp_stall_pct = 75;

      // reset symbols: one-byte frame of a flag value, its check stuffed too
      send_payload(8'h7E, 1'b0, 1'b1);
      // extremes, escape value, sequence bit ignored mid-frame
      send_payload(8'h00, 1'b1, 1'b0);
      send_payload(8'hFF, 1'b0, 1'b0);
      send_payload(8'h7D, 1'b0, 1'b0);
      send_payload(8'h80, 1'b1, 1'b1);
      // check comes out equal to the escape value
      send_payload(8'h10, 1'b0, 1'b0);
      send_payload(8'h6D, 1'b1, 1'b1);
      send_payload(8'h01, 1'b1, 1'b1);
      // leave a frame open across the next register writes
      send_payload(8'hAA, 1'b0, 1'b0);
      send_payload(8'h7D, 1'b1, 1'b0);

      // flag equal to escape, header bytes equal to the flag
      apply_settings(shared_symbols);
      send_payload(8'h55, 1'b0, 1'b1);
      send_payload(8'h55, 1'b1, 1'b1);
      send_payload(8'hAA, 1'b0, 1'b0);
      send_payload(8'h00, 1'b1, 1'b0);
      send_payload(8'hAA, 1'b0, 1'b1);

      // extreme symbol values
      apply_settings(extreme_symbols);
      send_payload(8'h00, 1'b1, 1'b0);
      send_payload(8'hFF, 1'b0, 1'b0);
      send_payload(8'hFF, 1'b1, 1'b1);
      send_payload(8'hFF, 1'b1, 1'b1);

      // random frames under three idling patterns, two symbol sets each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 8;  rsp_stall_pct = 75; end
            1: begin send_idle_pct = 75; rsp_stall_pct = 8;  end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int part = 0; part < 2; part++) begin
            apply_settings(random_symbols());
            repeat (RANDOM_PER_SETTING)
               send_payload(random_payload(), 1'($urandom_range(1)),
                            $urandom_range(3) == 0);
         end
      end

      drain();
      $display("%0d payload bytes in %0d closed frames under %0d symbol settings",
               sb.payload_count, sb.frame_count, settings_count + 1);
      $display("%0d line bytes checked, %0d stuffed values, %0d mismatches",
               sb.line_count, sb.escape_count, sb.mismatch_count);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
